// ===== design/fdmd_pkg.sv =====
// types and constants shared by the frame difference motion detector
// no dependencies
`default_nettype none

package fdmd_pkg;

  // field widths
  localparam int unsigned PixelW   = 8;
  localparam int unsigned CountW   = 23;
  localparam int unsigned LingerW  = 31;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned StateW   = 2;

  // largest frame the changed pixel count is sized for
  localparam int unsigned MaxFramePixels = 4194304;

  // register file
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;
  localparam int unsigned RegIdxW = 3;

  typedef enum logic [RegIdxW-1:0] {
    RegPixelThreshold = 3'd0,
    RegAlarmCount     = 3'd1,
    RegLingerMs       = 3'd2,
    RegAnalysisEnable = 3'd3,
    RegForceEnable    = 3'd4,
    RegForcedState    = 3'd5
  } reg_idx_e;

  // reset values of the registers
  localparam logic [PixelW-1:0]  ThresholdReset = 8'd16;
  localparam logic [CountW-1:0]  AlarmReset     = 23'd100;
  localparam logic [LingerW-1:0] LingerReset    = 31'd1000;

  // motion state
  typedef enum logic [StateW-1:0] {
    MotionIdle   = 2'd0,
    MotionActive = 2'd1,
    MotionLinger = 2'd2
  } motion_e;

  typedef struct packed {
    logic [PixelW-1:0] previous_pixel;
    logic [PixelW-1:0] current_pixel;
    logic              frame_end;
    logic [TimeW-1:0]  frame_time_ms;
  } fdmd_in_t;

  typedef struct packed {
    logic [StateW-1:0] motion_state;
    logic [CountW-1:0] changed_pixels;
  } fdmd_out_t;

  // configuration as seen by front and back
  typedef struct packed {
    logic [PixelW-1:0]  pixel_threshold;
    logic [CountW-1:0]  alarm_count;
    logic [LingerW-1:0] linger_ms;
    logic               analysis_enable;
    logic               force_enable;
    logic               forced_state;
  } fdmd_cfg_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic             changed;
    logic             frame_end;
    logic [TimeW-1:0] frame_time_ms;
  } fdmd_ent_t;

endpackage

`default_nettype wire

// ===== design/fdmd_front.sv =====
// front stage: classifies each pixel pair as changed or not
// depends on fdmd_pkg
`default_nettype none

module fdmd_front
  import fdmd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire fdmd_cfg_t cfg_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire fdmd_in_t  in_data_i,
  output logic           ent_valid_o,
  input  wire logic      ent_ready_i,
  output fdmd_ent_t      ent_o
);

  logic              valid_q, valid_d;
  fdmd_ent_t         ent_q, ent_d;
  logic [PixelW-1:0] diff;
  logic              analysing;

  // absolute difference against the threshold
  always_comb begin
    if (in_data_i.current_pixel > in_data_i.previous_pixel) begin
      diff = in_data_i.current_pixel - in_data_i.previous_pixel;
    end else begin
      diff = in_data_i.previous_pixel - in_data_i.current_pixel;
    end
    analysing = cfg_i.analysis_enable && !cfg_i.force_enable;
  end

  assign in_ready_o = !valid_q || ent_ready_i;

  // stage register
  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    if (in_ready_o) begin
      valid_d             = in_valid_i;
      ent_d.changed       = analysing && (diff > cfg_i.pixel_threshold);
      ent_d.frame_end     = in_data_i.frame_end;
      ent_d.frame_time_ms = in_data_i.frame_time_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_valid_o = valid_q;
  assign ent_o       = ent_q;

endmodule

`default_nettype wire

// ===== design/fdmd_queue.sv =====
// two-entry queue between front and back
// depends on fdmd_pkg
`default_nettype none

module fdmd_queue
  import fdmd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_valid_i,
  output logic           push_ready_o,
  input  wire fdmd_ent_t push_ent_i,
  output logic           pop_valid_o,
  input  wire logic      pop_ready_i,
  output fdmd_ent_t      pop_ent_o
);

  fdmd_ent_t   slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  fill_q, fill_d;
  logic        push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_ent_o = slot_q[rd_ptr_q];

  // pointers and fill level
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_ent_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/fdmd_back.sv =====
// back stage: counts changed pixels, updates the motion state at frame end
// depends on fdmd_pkg
`default_nettype none

module fdmd_back
  import fdmd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire fdmd_cfg_t cfg_i,
  input  wire logic      ent_valid_i,
  output logic           ent_ready_o,
  input  wire fdmd_ent_t ent_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output fdmd_out_t      out_data_o
);

  motion_e           motion_q, motion_d;
  logic [CountW-1:0] count_q, count_d;
  logic [TimeW-1:0]  start_q, start_d;
  logic              out_valid_q, out_valid_d;
  fdmd_out_t         out_q, out_d;

  logic              take, frame_done, analysing;
  logic [CountW-1:0] cap, count_next;
  logic [TimeW-1:0]  elapsed;

  assign ent_ready_o = !out_valid_q || out_ready_i;
  assign take        = ent_valid_i && ent_ready_o;
  assign frame_done  = take && ent_i.frame_end;
  assign analysing   = cfg_i.analysis_enable && !cfg_i.force_enable;

  // saturating changed pixel count
  always_comb begin
    if (TimeW'(cfg_i.alarm_count) > TimeW'(MaxFramePixels)) begin
      cap = CountW'(MaxFramePixels);
    end else begin
      cap = cfg_i.alarm_count;
    end
    count_next = count_q;
    if (ent_i.changed && (count_q < cap)) begin
      count_next = count_q + CountW'(1);
    end
    count_d = count_q;
    if (take) begin
      count_d = ent_i.frame_end ? '0 : count_next;
    end
  end

  assign elapsed = ent_i.frame_time_ms - start_q;

  // motion state next value
  always_comb begin
    motion_d = motion_q;
    start_d  = start_q;
    if (frame_done && cfg_i.analysis_enable) begin
      if (cfg_i.force_enable) begin
        motion_d = cfg_i.forced_state ? MotionActive : MotionIdle;
      end else if (count_next >= cfg_i.alarm_count) begin
        motion_d = MotionActive;
      end else begin
        unique case (motion_q)
          MotionActive: begin
            start_d  = ent_i.frame_time_ms;
            motion_d = MotionLinger;
          end
          MotionLinger: begin
            if (elapsed >= {1'b0, cfg_i.linger_ms}) begin
              motion_d = MotionIdle;
            end
          end
          default: begin
            motion_d = motion_q;
          end
        endcase
      end
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (ent_ready_o) begin
      out_valid_d = frame_done;
    end
    if (frame_done) begin
      out_d.motion_state   = motion_d;
      out_d.changed_pixels = analysing ? count_next : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motion_q    <= MotionIdle;
      count_q     <= '0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      motion_q    <= motion_d;
      count_q     <= count_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== design/frame_difference_motion_detector_core.sv =====
// top level of the frame difference motion detector: register file and wiring
// depends on fdmd_pkg, fdmd_front, fdmd_queue, fdmd_back
`default_nettype none

// Takes one pixel pair per beat (previous and current frame luma) and counts
// pixels whose absolute difference is above pixel_threshold, saturating at
// alarm_count or MaxFramePixels, whichever is smaller. The beat that carries
// frame_end produces one result beat with the updated motion state (0 idle,
// 1 motion, 2 lingering) and the frame's changed pixel count; other beats
// produce nothing. A new pixel is accepted every clock while the output is
// not stalled: classification is one register stage, a two-entry queue
// decouples it from the counting stage, and the result sits in an output
// register, so a result beat passes through the front register, a queue
// slot and the output register. While a result waits, the front takes up to
// three more pixels before it stalls. Registers sit on an APB port at byte
// addresses 4*i and are to be written only while the block is idle.
module frame_difference_motion_detector_core
  import fdmd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire fdmd_in_t         in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output fdmd_out_t             out_data_o
);

  fdmd_cfg_t cfg_q, cfg_d;
  reg_idx_e  reg_idx;
  logic      wr_en;

  logic      fr_valid, fr_ready;
  fdmd_ent_t fr_ent;
  logic      bk_valid, bk_ready;
  fdmd_ent_t bk_ent;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;

  // register writes
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegPixelThreshold: cfg_d.pixel_threshold = pwdata[PixelW-1:0];
        RegAlarmCount:     cfg_d.alarm_count     = pwdata[CountW-1:0];
        RegLingerMs:       cfg_d.linger_ms       = pwdata[LingerW-1:0];
        RegAnalysisEnable: cfg_d.analysis_enable = pwdata[0];
        RegForceEnable:    cfg_d.force_enable    = pwdata[0];
        RegForcedState:    cfg_d.forced_state    = pwdata[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      RegPixelThreshold: prdata = DataW'(cfg_q.pixel_threshold);
      RegAlarmCount:     prdata = DataW'(cfg_q.alarm_count);
      RegLingerMs:       prdata = DataW'(cfg_q.linger_ms);
      RegAnalysisEnable: prdata = DataW'(cfg_q.analysis_enable);
      RegForceEnable:    prdata = DataW'(cfg_q.force_enable);
      RegForcedState:    prdata = DataW'(cfg_q.forced_state);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_threshold <= ThresholdReset;
      cfg_q.alarm_count     <= AlarmReset;
      cfg_q.linger_ms       <= LingerReset;
      cfg_q.analysis_enable <= 1'b1;
      cfg_q.force_enable    <= 1'b0;
      cfg_q.forced_state    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pixel classification
  fdmd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .ent_valid_o (fr_valid),
    .ent_ready_i (fr_ready),
    .ent_o       (fr_ent)
  );

  // decoupling queue
  fdmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_ent_i   (fr_ent),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_ent_o    (bk_ent)
  );

  // counting and motion state
  fdmd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .ent_valid_i (bk_valid),
    .ent_ready_o (bk_ready),
    .ent_i       (bk_ent),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
